// ----- src/mf2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared types and constants for the 2D streaming median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

   // Port payload widths
   localparam int PIX_IO_BITS   = 8;
   localparam int COORD_BITS    = 10;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 11;

   // Height handling: rows per image are capped, row counter arithmetic width
   localparam int HEIGHT_BITS  = 11;
   localparam int ROW_BITS     = 10;
   localparam int HEIGHT_CAP   = 1024;
   localparam int DEFAULT_SIZE = 512;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Position info carried down the pipe with each filtered pixel
   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  last;
   } mf2d_meta_type;

endpackage

// ----- src/median_filter_2d.sv -----
// ----------------------------------------------------------------------------
// median_filter_2d
// Streaming WINDOW_SIZE x WINDOW_SIZE median filter over raster-order pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns, for every pixel whose
// full window lies inside the image, the median of the window with the center's
// column and row; border pixels produce no beat. The previous WINDOW_SIZE-1 rows
// live in one RAM of MAX_WIDTH words, each word holding one column of stored
// rows, so every pixel costs one read and one write of that RAM; a column read
// in the same cycle as it is written is forwarded. A result passes through the
// RAM read, window shift, compare, rank and output register stages in order.
// A stalled output beat holds the whole pipe, so req_stall follows rsp_stall
// while a result waits. The line store has no clearing pass after reset: rows
// that feed a result are always written before they are read within an image.
// image_width and image_height may only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module median_filter_2d #(
   parameter int WINDOW_SIZE = 3,
   parameter int MAX_WIDTH   = 1024,
   parameter int PIXEL_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mf2d_pkg::PIX_IO_BITS-1:0]   req_pixel_value,
   input  logic                               req_frame_start,
   // filtered output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mf2d_pkg::PIX_IO_BITS-1:0]   rsp_median_value,
   output logic [mf2d_pkg::COORD_BITS-1:0]    rsp_center_col,
   output logic [mf2d_pkg::COORD_BITS-1:0]    rsp_center_row,
   output logic                               rsp_frame_end,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mf2d_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [mf2d_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import mf2d_pkg::*;

   localparam int WIN_AREA   = WINDOW_SIZE * WINDOW_SIZE;
   localparam int MID        = WIN_AREA / 2;
   localparam int HALF       = WINDOW_SIZE / 2;
   localparam int STORE_ROWS = WINDOW_SIZE - 1;
   localparam int AW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int CW         = WW + 1;
   localparam int SW         = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int RKW        = $clog2(WIN_AREA);
   localparam int WORD_BITS  = STORE_ROWS * PIXEL_BITS;
   localparam int RESET_W    = (DEFAULT_SIZE > MAX_WIDTH) ? MAX_WIDTH : DEFAULT_SIZE;

   // next line-store slot, wrapping at STORE_ROWS
   function automatic logic [SW-1:0] slot_step(input logic [SW-1:0] s);
      slot_step = (s == SW'(STORE_ROWS - 1)) ? '0 : s + 1'b1;
   endfunction

   // (s + r) mod STORE_ROWS for s < STORE_ROWS and r < STORE_ROWS
   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] s, input int r);
      logic [SW:0] t;
      t = {1'b0, s} + (SW+1)'(r);
      if (t >= (SW+1)'(STORE_ROWS)) begin
         t = t - (SW+1)'(STORE_ROWS);
      end
      slot_add = SW'(t);
   endfunction

   // ---------------------------------------------------------------------
   // Pipe control: everything moves unless a finished beat is stalled
   // ---------------------------------------------------------------------
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Size registers, held to their legal ranges on write
   // ---------------------------------------------------------------------
   logic [WW-1:0]          width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH: begin
               if (32'(csr_wdata) < WINDOW_SIZE) width_in = WW'(WINDOW_SIZE);
               else if (32'(csr_wdata) > MAX_WIDTH) width_in = WW'(MAX_WIDTH);
               else width_in = WW'(csr_wdata);
            end
            CSR_IMAGE_HEIGHT: begin
               if (32'(csr_wdata) < WINDOW_SIZE) height_in = HEIGHT_BITS'(WINDOW_SIZE);
               else if (32'(csr_wdata) > HEIGHT_CAP) height_in = HEIGHT_BITS'(HEIGHT_CAP);
               else height_in = HEIGHT_BITS'(csr_wdata);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RESET_W);
         height_ff <= HEIGHT_BITS'(DEFAULT_SIZE);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Position counters (stage 0)
   // ---------------------------------------------------------------------
   logic [AW-1:0]          col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [SW-1:0]          slot_ff, slot_in;

   logic [AW-1:0]          col0, col_c;
   logic [HEIGHT_BITS-1:0] row0, row1, row_c, row_n;
   logic [SW-1:0]          slot0, slot1, slot_c;
   logic [CW-1:0]          col_n;
   logic                   emit_c;
   mf2d_meta_type          meta_c;
   logic [PIXEL_BITS-1:0]  pix_c;

   always_comb begin
      // frame start clears, then wrap anything past the current size
      col0  = req_frame_start ? '0 : col_ff;
      row0  = req_frame_start ? '0 : HEIGHT_BITS'(row_ff);
      slot0 = req_frame_start ? '0 : slot_ff;
      if (CW'(col0) >= CW'(width_ff)) begin
         col_c = '0;
         row1  = row0 + 1'b1;
         slot1 = slot_step(slot0);
      end else begin
         col_c = col0;
         row1  = row0;
         slot1 = slot0;
      end
      if (row1 >= height_ff) begin
         row_c  = '0;
         slot_c = '0;
      end else begin
         row_c  = row1;
         slot_c = slot1;
      end

      // advance past this pixel
      col_n = CW'(col_c) + 1'b1;
      row_n = row_c + 1'b1;
      if (col_n >= CW'(width_ff)) begin
         col_in = '0;
         if (row_n >= height_ff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = ROW_BITS'(row_n);
            slot_in = slot_step(slot_c);
         end
      end else begin
         col_in  = AW'(col_n);
         row_in  = ROW_BITS'(row_c);
         slot_in = slot_c;
      end

      emit_c = (row_c >= HEIGHT_BITS'(WINDOW_SIZE - 1)) && (col_c >= AW'(WINDOW_SIZE - 1));
      meta_c.col  = COORD_BITS'(col_c - AW'(HALF));
      meta_c.row  = COORD_BITS'(row_c - HEIGHT_BITS'(HALF));
      meta_c.last = (row_c == height_ff - 1'b1) && (CW'(col_c) == CW'(width_ff) - 1'b1);
      pix_c = PIXEL_BITS'(req_pixel_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line-store read in flight
   // ---------------------------------------------------------------------
   logic                  s1_valid_ff;
   logic                  s1_emit_ff;
   logic [AW-1:0]         s1_col_ff;
   logic [SW-1:0]         s1_slot_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   mf2d_meta_type         s1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit_c;
         s1_col_ff  <= col_c;
         s1_slot_ff <= slot_c;
         s1_pix_ff  <= pix_c;
         s1_meta_ff <= meta_c;
      end
   end

   // line store RAM: one word per column, one pixel per stored row
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data, wr_word, line_word;

   assign ram_rd_en   = accept;
   assign ram_rd_addr = col_c;
   assign ram_wr_en   = adv && s1_valid_ff;
   assign ram_wr_addr = s1_col_ff;

   mf2d_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // forward a word written in the same cycle as its column was read
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [WORD_BITS-1:0] fwd_word_ff;

   assign fwd_hit_in = accept && s1_valid_ff && (s1_col_ff == col_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (adv) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_word_ff <= wr_word;
      end
   end

   assign line_word = fwd_hit_ff ? fwd_word_ff : ram_rd_data;

   // current pixel replaces the oldest stored row at this column
   always_comb begin
      for (int s = 0; s < STORE_ROWS; s++) begin
         wr_word[s*PIXEL_BITS +: PIXEL_BITS] = (SW'(s) == s1_slot_ff) ? s1_pix_ff
                                             : line_word[s*PIXEL_BITS +: PIXEL_BITS];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: window registers, slide one column left per pixel
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] window_ff [WINDOW_SIZE][WINDOW_SIZE];
   logic [PIXEL_BITS-1:0] window_in [WINDOW_SIZE][WINDOW_SIZE];
   logic                  s2_valid_ff;
   mf2d_meta_type         s2_meta_ff;

   always_comb begin
      for (int r = 0; r < WINDOW_SIZE; r++) begin
         for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
            window_in[r][c] = window_ff[r][c+1];
         end
      end
      // new right column: oldest stored row on top, current pixel at bottom
      for (int r = 0; r < STORE_ROWS; r++) begin
         window_in[r][WINDOW_SIZE-1] =
            line_word[slot_add(s1_slot_ff, r)*PIXEL_BITS +: PIXEL_BITS];
      end
      window_in[WINDOW_SIZE-1][WINDOW_SIZE-1] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: pairwise compares, ties broken by position
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] win_flat [WIN_AREA];
   logic [WIN_AREA-1:0]   less_in  [WIN_AREA];
   logic [WIN_AREA-1:0]   s3_less_ff [WIN_AREA];
   logic [PIXEL_BITS-1:0] s3_vals_ff [WIN_AREA];
   logic                  s3_valid_ff;
   mf2d_meta_type         s3_meta_ff;

   always_comb begin
      for (int r = 0; r < WINDOW_SIZE; r++) begin
         for (int c = 0; c < WINDOW_SIZE; c++) begin
            win_flat[r*WINDOW_SIZE + c] = window_ff[r][c];
         end
      end
      // less_in[i][j]: element j sorts ahead of element i
      for (int i = 0; i < WIN_AREA; i++) begin
         for (int j = 0; j < WIN_AREA; j++) begin
            if (j == i) less_in[i][j] = 1'b0;
            else if (j < i) less_in[i][j] = (win_flat[j] <= win_flat[i]);
            else less_in[i][j] = (win_flat[j] < win_flat[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_less_ff <= less_in;
         s3_vals_ff <= win_flat;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: ranks form a permutation; pick the element ranked in the middle
   // ---------------------------------------------------------------------
   logic [RKW-1:0]        rank_c [WIN_AREA];
   logic [WIN_AREA-1:0]   sel_in;
   logic [WIN_AREA-1:0]   s4_sel_ff;
   logic [PIXEL_BITS-1:0] s4_vals_ff [WIN_AREA];
   logic                  s4_valid_ff;
   mf2d_meta_type         s4_meta_ff;

   always_comb begin
      for (int i = 0; i < WIN_AREA; i++) begin
         rank_c[i] = '0;
         for (int j = 0; j < WIN_AREA; j++) begin
            rank_c[i] = rank_c[i] + RKW'(s3_less_ff[i][j]);
         end
         sel_in[i] = (rank_c[i] == RKW'(MID));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sel_ff  <= sel_in;
         s4_vals_ff <= s3_vals_ff;
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0]  med_c;
   logic [PIX_IO_BITS-1:0] rsp_med_ff;
   mf2d_meta_type          rsp_meta_ff;

   always_comb begin
      med_c = '0;
      for (int i = 0; i < WIN_AREA; i++) begin
         med_c = med_c | ({PIXEL_BITS{s4_sel_ff[i]}} & s4_vals_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_med_ff  <= PIX_IO_BITS'(med_c);
         rsp_meta_ff <= s4_meta_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_med_ff;
   assign rsp_center_col   = rsp_meta_ff.col;
   assign rsp_center_row   = rsp_meta_ff.row;
   assign rsp_frame_end    = rsp_meta_ff.last;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   // exactly one window element holds the middle rank
   a_median_onehot: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> $onehot(s4_sel_ff))
      else $error("median select is not one-hot");

   // slot tracks row modulo stored rows
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SW'(STORE_ROWS - 1))
      else $error("line-store slot out of range");

   // a same-column read and write must be covered by forwarding
   a_fwd_on_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)) |=> fwd_hit_ff)
      else $error("line-store collision not forwarded");

   // a held pipe keeps its read stage in place
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stage 1 moved while stalled");
`endif

endmodule

// ----- src/mf2d_ram.sv -----
// ----------------------------------------------------------------------------
// mf2d_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mf2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
